/* hdl/ssoa_pkg.sv */
`default_nettype none

package ssoa_pkg;

   localparam int unsigned MAX_SCAN_SAMPLES = 1024;

   localparam int unsigned LEN_W    = 11;
   localparam int unsigned RANGE_W  = 17;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned IDX_W    = 10;
   localparam int unsigned FIFTH_W  = 8;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 17;

   localparam logic [RANGE_W-1:0] RANGE_START_MM = RANGE_W'(100000);
   localparam logic signed [SPEED_W-1:0] TURN_AWAY_MRAD = SPEED_W'(1500);

   // reset values of the configuration registers
   localparam logic [LEN_W-1:0]   SCAN_LENGTH_RST    = LEN_W'(360);
   localparam logic [RANGE_W-1:0] OBSTACLE_LIMIT_RST = RANGE_W'(500);
   localparam logic [FIFTH_W-1:0] FIFTH_RST          = FIFTH_W'(360 / 5);

   localparam logic [MODE_W-1:0] MODE_PASS   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_ASSIST = MODE_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_LENGTH    = 2'd0,
      CSR_OBSTACLE_LIMIT = 2'd1,
      CSR_MODE           = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                      command;
      logic [RANGE_W-1:0]        range_mm;
      logic signed [SPEED_W-1:0] cmd_linear;
      logic signed [SPEED_W-1:0] cmd_angular;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] out_linear;
      logic signed [SPEED_W-1:0] out_angular;
      logic                      front_blocked;
      logic                      left_close;
      logic                      right_close;
   } rsp_type;

   // settings as seen by the datapath
   typedef struct packed {
      logic [LEN_W-1:0]   scan_len;
      logic [FIFTH_W-1:0] fifth;
      logic [RANGE_W-1:0] obstacle_limit;
      logic [MODE_W-1:0]  mode;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/ssoa_csr.sv */
`default_nettype none

module ssoa_csr
   import ssoa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output      cfg_type               cfg
);

   // 3277 / 2**14 is just above 1/5, exact floor for lengths up to 1024
   localparam int unsigned RECIP_W     = 12;
   localparam int unsigned RECIP_SHIFT = 14;
   localparam logic [RECIP_W-1:0] RECIP_FIFTH = RECIP_W'(3277);
   localparam int unsigned PROD_W = LEN_W + RECIP_W;

   logic [LEN_W-1:0]   scan_length_ff, scan_length_in;
   logic [RANGE_W-1:0] safety_ff, safety_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [FIFTH_W-1:0] fifth_ff, fifth_in;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      scan_length_in = scan_length_ff;
      safety_in      = safety_ff;
      mode_in        = mode_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_SCAN_LENGTH:    scan_length_in = wr_data[LEN_W-1:0];
            CSR_OBSTACLE_LIMIT: safety_in      = wr_data[RANGE_W-1:0];
            CSR_MODE:           mode_in        = wr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp to 1 .. max, then divide by five
   always_comb begin
      if (scan_length_ff == '0) begin
         len_in = LEN_W'(1);
      end else if (scan_length_ff > LEN_W'(MAX_SCAN_SAMPLES)) begin
         len_in = LEN_W'(MAX_SCAN_SAMPLES);
      end else begin
         len_in = scan_length_ff;
      end
      prod     = PROD_W'(len_in) * PROD_W'(RECIP_FIFTH);
      fifth_in = prod[RECIP_SHIFT +: FIFTH_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_length_ff <= SCAN_LENGTH_RST;
         safety_ff      <= OBSTACLE_LIMIT_RST;
         mode_ff        <= '0;
         len_ff         <= SCAN_LENGTH_RST;
         fifth_ff       <= FIFTH_RST;
      end else begin
         scan_length_ff <= scan_length_in;
         safety_ff      <= safety_in;
         mode_ff        <= mode_in;
         len_ff         <= len_in;
         fifth_ff       <= fifth_in;
      end
   end

   assign cfg.scan_len       = len_ff;
   assign cfg.fifth          = fifth_ff;
   assign cfg.obstacle_limit = safety_ff;
   assign cfg.mode           = mode_ff;

endmodule

`default_nettype wire

/* hdl/ssoa_core.sv */
`default_nettype none

module ssoa_core
   import ssoa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output      logic    res_valid,
   output      rsp_type res
);

   logic signed [SPEED_W-1:0] held_lin_ff, held_lin_in;
   logic signed [SPEED_W-1:0] held_ang_ff, held_ang_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [RANGE_W-1:0]        min_left_ff, min_left_in;
   logic [RANGE_W-1:0]        min_front_ff, min_front_in;
   logic [RANGE_W-1:0]        min_right_ff, min_right_in;

   logic [IDX_W-1:0]   f1, f2, f3, f4;
   logic               in_left, in_front, in_right;
   logic [RANGE_W-1:0] new_left, new_front, new_right;
   logic               last;
   logic               assist;
   logic               fb, lc, rc;

   always_comb begin
      f1 = IDX_W'(cfg.fifth);
      f2 = f1 << 1;
      f3 = f1 + f2;
      f4 = f2 << 1;

      in_left  = (idx_ff >= f1 + IDX_W'(1)) && (idx_ff < f2);
      in_front = (idx_ff >= f2 + IDX_W'(1)) && (idx_ff < f3);
      in_right = (idx_ff >= f3 + IDX_W'(1)) && (idx_ff < f4);

      new_left  = (in_left  && item.range_mm < min_left_ff)  ? item.range_mm : min_left_ff;
      new_front = (in_front && item.range_mm < min_front_ff) ? item.range_mm : min_front_ff;
      new_right = (in_right && item.range_mm < min_right_ff) ? item.range_mm : min_right_ff;

      last   = ({1'b0, idx_ff} + LEN_W'(1)) >= cfg.scan_len;
      assist = (cfg.mode == MODE_ASSIST);

      fb = assist && (new_front < cfg.obstacle_limit) && (held_lin_ff > SPEED_W'(0));
      lc = assist && (new_left < cfg.obstacle_limit);
      rc = assist && !lc && (new_right < cfg.obstacle_limit);

      held_lin_in  = held_lin_ff;
      held_ang_in  = held_ang_ff;
      idx_in       = idx_ff;
      min_left_in  = min_left_ff;
      min_front_in = min_front_ff;
      min_right_in = min_right_ff;
      res_valid    = 1'b0;

      if (!item.command) begin
         held_lin_in = item.cmd_linear;
         held_ang_in = item.cmd_angular;
      end else if (!last) begin
         idx_in       = idx_ff + IDX_W'(1);
         min_left_in  = new_left;
         min_front_in = new_front;
         min_right_in = new_right;
      end else begin
         if (fb) begin
            held_lin_in = '0;
         end
         if (lc) begin
            held_ang_in = TURN_AWAY_MRAD;
         end else if (rc) begin
            held_ang_in = -TURN_AWAY_MRAD;
         end
         idx_in       = '0;
         min_left_in  = RANGE_START_MM;
         min_front_in = RANGE_START_MM;
         min_right_in = RANGE_START_MM;
         res_valid    = (cfg.mode inside {MODE_PASS, MODE_ASSIST});
      end

      res.out_linear    = held_lin_in;
      res.out_angular   = held_ang_in;
      res.front_blocked = fb;
      res.left_close    = lc;
      res.right_close   = rc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         idx_ff       <= '0;
         min_left_ff  <= RANGE_START_MM;
         min_front_ff <= RANGE_START_MM;
         min_right_ff <= RANGE_START_MM;
      end else if (en) begin
         held_lin_ff  <= held_lin_in;
         held_ang_ff  <= held_ang_in;
         idx_ff       <= idx_in;
         min_left_ff  <= min_left_in;
         min_front_ff <= min_front_in;
         min_right_ff <= min_right_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/scan_sector_obstacle_assist.sv */
// channel   | direction | handshake              | beat
// ----------+-----------+------------------------+--------------------------
// req_      | in        | req_valid / req_stall  | command or one range sample
// rsp_      | out       | rsp_valid / rsp_stall  | drive command and flags
// csr_      | in        | csr_valid / csr_ready  | register index and data
//
// one beat per cycle in while the result register is not stalled; a result passes
// through the input register and then the result register, with the sector
// minimum compare and held-command update done combinationally between them
// reset is synchronous and resets the sector minima, index and held command
// a stalled result holds the whole pipe, the input register still fills once
// a register write applies to beats arriving from the next cycle on
`default_nettype none

module scan_sector_obstacle_assist
   import ssoa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_data,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_data,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    advance;
   logic    req_take;
   logic    res_valid;
   rsp_type res;

   // writes are always taken
   assign csr_ready = 1'b1;

   ssoa_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // the result register is free, or is being emptied this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ssoa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .en        (in_valid_ff && advance),
      .item      (in_data_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = req_take;
      end else if (!in_valid_ff) begin
         in_valid_in = req_take;
      end
      out_valid_in = advance ? (in_valid_ff && res_valid) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* hdl/ssoa_checker.sv */
`default_nettype none

module ssoa_checker
   import ssoa_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rsp_type               rsp_data
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a stopped robot reports zero forward speed
   a_front_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.front_blocked |-> rsp_data.out_linear == '0)
      else $error("front blocked with non-zero speed");

   // only one wall decides the turn, and the turn matches it
   a_turn_left_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.left_close |->
         !rsp_data.right_close && rsp_data.out_angular == TURN_AWAY_MRAD)
      else $error("left wall turn wrong");

   a_turn_right_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.right_close |-> rsp_data.out_angular == -TURN_AWAY_MRAD)
      else $error("right wall turn wrong");

endmodule

bind scan_sector_obstacle_assist ssoa_checker u_ssoa_checker (.*);

`default_nettype wire
